>>> rtl/bss_pkg.sv
// Shared types and constants for the bounded stack with search.
package bss_pkg;

	localparam int DEPTH    = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 6;
	localparam int OP_W     = 2;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Status from the compare unit back to the sequencer.
	typedef struct packed {
		logic             hit;
		logic             last;
		logic [IDX_W-1:0] idx;
	} cmp_stat_t;

endpackage

>>> rtl/bss_mem.sv
// Stack entry storage: one write port, one registered read port.
module bss_mem
	import bss_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/bss_cmp.sv
// Compare unit: matches each entry read during a search against the key.
module bss_cmp
	import bss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue,
	input  logic [IDX_W-1:0]  issue_idx,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] rd_data,
	input  logic [CNT_W-1:0]  cnt,
	output cmp_stat_t         stat
);

	logic             pend_q;
	logic [IDX_W-1:0] pend_idx_q;

	// a read issued this cycle has its data in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pend_idx_q <= issue_idx;
		end
	end

	always_comb begin
		stat.hit  = pend_q && (rd_data == key);
		stat.last = pend_q && ((CNT_W'(pend_idx_q) + CNT_W'(1)) == cnt);
		stat.idx  = pend_idx_q;
	end

endmodule

>>> rtl/bounded_stack_with_search.sv
// Top level of the bounded stack with search: sequencer, storage and compare unit.
//
// Input stream (s_*): one request per item, op in s_tuser, value in s_tdata.
// Output stream (m_*): exactly one result per request, in request order.
// Push and clear finish in the accept cycle; their result is shown on the
// next cycle. Pop reads the top entry, captures it, and then loads the
// result. Search reads the entries from the bottom, one per cycle, through
// the single read port and compares each in the compare unit; it stops at
// the first match or after the top entry. An empty stack answers pop and
// search at once.
// s_tready is high only while the sequencer is idle and the output register
// is free or being emptied; a result waiting on a stalled m_tready blocks
// the next request, and holds a finished pop or search until it can load.
// Reset (arst_n low) empties the stack and drops any pending result;
// entry contents are not cleared, since only entries below the count are
// ever read.
module bounded_stack_with_search
	import bss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0]
	input  logic [OP_W-1:0]        s_tuser,   // op[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // data[31:0], position[36:32], count[42:37], zero pad
	output logic                   m_tuser    // ok
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    scan_q;
	logic [DATA_W-1:0]   key_q;
	logic                res_ok_q;
	logic [DATA_W-1:0]   res_data_q;
	logic [POS_W-1:0]    res_pos_q;
	logic                m_tvalid_q;
	logic                m_ok_q;
	logic [DATA_W-1:0]   m_data_q;
	logic [POS_W-1:0]    m_pos_q;
	logic [COUNT_W-1:0]  m_count_q;

	logic                out_free;
	logic                accept;
	logic                m_load;
	op_t                 op;
	logic                wr_en;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [DATA_W-1:0]   rd_data;
	logic                scan_issue;
	cmp_stat_t           cmp_stat;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);

	// output register takes a result: immediate answers or a finished long op
	assign m_load = (accept && ((op == OP_PUSH) || (op == OP_CLEAR) || (cnt_q == '0)))
		|| ((state_q == ST_FIN) && out_free);

	assign wr_en      = accept && (op == OP_PUSH) && (cnt_q < CNT_W'(DEPTH));
	assign scan_issue = (state_q == ST_SCAN) && (scan_q < cnt_q)
		&& !cmp_stat.hit && !cmp_stat.last;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[IDX_W-1:0];
		if (accept && (op == OP_POP) && (cnt_q != '0)) begin
			rd_en   = 1'b1;
			rd_addr = IDX_W'(cnt_q - CNT_W'(1));
		end else if (scan_issue) begin
			rd_en = 1'b1;
		end
	end

	bss_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bss_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (scan_issue),
		.issue_idx (scan_q[IDX_W-1:0]),
		.key       (key_q),
		.rd_data   (rd_data),
		.cnt       (cnt_q),
		.stat      (cmp_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			scan_q     <= '0;
			key_q      <= '0;
			res_ok_q   <= 1'b0;
			res_data_q <= '0;
			res_pos_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_ok_q     <= 1'b0;
			m_data_q   <= '0;
			m_pos_q    <= '0;
			m_count_q  <= '0;
		end else begin
			if (m_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_PUSH: begin
								m_data_q   <= '0;
								m_pos_q    <= '0;
								if (wr_en) begin
									cnt_q     <= cnt_q + CNT_W'(1);
									m_ok_q    <= 1'b1;
									m_count_q <= COUNT_W'(cnt_q + CNT_W'(1));
								end else begin
									m_ok_q    <= 1'b0;
									m_count_q <= COUNT_W'(cnt_q);
								end
							end
							OP_POP: begin
								if (cnt_q == '0) begin
									m_ok_q     <= 1'b0;
									m_data_q   <= '0;
									m_pos_q    <= '0;
									m_count_q  <= '0;
								end else begin
									cnt_q   <= cnt_q - CNT_W'(1);
									state_q <= ST_POP;
								end
							end
							OP_SEARCH: begin
								if (cnt_q == '0) begin
									m_ok_q     <= 1'b0;
									m_data_q   <= '0;
									m_pos_q    <= '0;
									m_count_q  <= '0;
								end else begin
									key_q   <= s_tdata;
									scan_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
							OP_CLEAR: begin
								cnt_q      <= '0;
								m_ok_q     <= 1'b1;
								m_data_q   <= '0;
								m_pos_q    <= '0;
								m_count_q  <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_POP: begin
					res_ok_q   <= 1'b1;
					res_data_q <= rd_data;
					res_pos_q  <= '0;
					state_q    <= ST_FIN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					res_data_q <= '0;
					if (cmp_stat.hit) begin
						res_ok_q  <= 1'b1;
						res_pos_q <= POS_W'(cmp_stat.idx);
						state_q   <= ST_FIN;
					end else if (cmp_stat.last) begin
						res_ok_q  <= 1'b0;
						res_pos_q <= '0;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_ok_q     <= res_ok_q;
						m_data_q   <= res_data_q;
						m_pos_q    <= res_pos_q;
						m_count_q  <= COUNT_W'(cnt_q);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_ok_q;
	assign m_tdata  = {{(OUT_TDATA_W - DATA_W - POS_W - COUNT_W){1'b0}},
		m_count_q, m_pos_q, m_data_q};

endmodule
